// ===== rtl/hpe_pkg.sv =====
`timescale 1ns / 1ps

package hpe_pkg;

    // Default sizes
    localparam int COORD_BITS_DEFAULT  = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Commands on the input channel
    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_SETPOS = 2'd2;
    localparam logic [1:0] CMD_IDLE   = 2'd3;

    // Flag bytes
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'

    // Digit ranges
    localparam logic [7:0] B64_TERM_LO = 8'd191;
    localparam logic [7:0] B64_TERM_HI = 8'd254;
    localparam logic [7:0] B64_LO      = 8'd63;
    localparam logic [7:0] B64_HI      = 8'd126;
    localparam logic [7:0] B32_TERM_LO = 8'd95;
    localparam logic [7:0] B32_TERM_HI = 8'd126;
    localparam logic [7:0] B32_LO      = 8'd63;
    localparam logic [7:0] B32_HI      = 8'd94;

    // Bits per digit and digit counter limit
    localparam logic [5:0] B64_DIGIT_BITS = 6'd6;
    localparam logic [5:0] B32_DIGIT_BITS = 6'd5;
    localparam logic [2:0] DIGIT_COUNT_MAX = 3'd7;

    // Operations passed from front to back
    localparam logic [2:0] OP_BEGIN    = 3'd0;
    localparam logic [2:0] OP_SETPOS   = 3'd1;
    localparam logic [2:0] OP_DIGIT    = 3'd2;
    localparam logic [2:0] OP_END      = 3'd3;
    localparam logic [2:0] OP_MARK     = 3'd4;
    localparam logic [2:0] OP_PEN_UP   = 3'd5;
    localparam logic [2:0] OP_PEN_DOWN = 3'd6;
    localparam logic [2:0] OP_ABS      = 3'd7;

    // Configuration register select (paddr[2])
    localparam logic REG_ROTATE_QUARTER = 1'b0;

    typedef struct packed {
        logic [2:0]  kind;
        logic        base_32;
        logic [5:0]  digit;
        logic        term;
        logic [31:0] set_x;
        logic [31:0] set_y;
    } op_t;

endpackage

// ===== rtl/hpgl_encoded_polyline_decoder.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// item in  | item_valid/item_stall| command, byte_value, set_x, set_y
// seg out  | seg_valid/seg_stall  | drawn, start_x, start_y, end_x, end_y
// config   | APB psel/penable     | paddr[2:0], pwdata, prdata (rotate_quarter)
//
// One word is accepted per cycle while the operation queue is not full; the back end
// retires one queued operation per cycle unless a finished point waits on a full result
// register, so the sustained rate is one word a cycle while seg_stall is low. A segment
// passes from its closing word through the queue entry, the back end result register, then the output register.
// item_stall rises only when the operation queue is full; seg_stall backs up
// through the output and result registers into the queue.
// rst_n clears position, pen, stream flags, queue and valid bits at once, and sets the relative flag.

module hpgl_encoded_polyline_decoder
#(
    parameter int COORD_BITS  = hpe_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = hpe_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         command,
    input  logic [7:0]         byte_value,
    input  logic signed [31:0] set_x,
    input  logic signed [31:0] set_y,

    output logic               seg_valid,
    input  logic               seg_stall,
    output logic               drawn,
    output logic signed [31:0] start_x,
    output logic signed [31:0] start_y,
    output logic signed [31:0] end_x,
    output logic signed [31:0] end_y
);

    logic                  rotate_reg;
    logic                  push, queue_full, pop, nonempty;
    hpe_pkg::op_t          push_op, head_op;
    logic                  res_valid, res_take, res_drawn;
    logic [COORD_BITS-1:0] res_sx, res_sy, res_ex, res_ey;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == hpe_pkg::REG_ROTATE_QUARTER)
        begin
            rotate_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == hpe_pkg::REG_ROTATE_QUARTER) ? {31'd0, rotate_reg} : 32'd0;

    hpe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .command    (command),
        .byte_value (byte_value),
        .set_x      (set_x),
        .set_y      (set_y),
        .queue_full (queue_full),
        .push       (push),
        .op         (push_op)
    );

    hpe_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .full     (queue_full),
        .pop      (pop),
        .nonempty (nonempty),
        .head_op  (head_op)
    );

    hpe_back
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (nonempty),
        .op        (head_op),
        .pop       (pop),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_drawn (res_drawn),
        .res_sx    (res_sx),
        .res_sy    (res_sy),
        .res_ex    (res_ex),
        .res_ey    (res_ey)
    );

    hpe_out
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rotate    (rotate_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_drawn (res_drawn),
        .res_sx    (res_sx),
        .res_sy    (res_sy),
        .res_ex    (res_ex),
        .res_ey    (res_ey),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .drawn     (drawn),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y)
    );

endmodule

// ===== rtl/hpe_front.sv =====
`timescale 1ns / 1ps

module hpe_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          command,
    input  logic [7:0]          byte_value,
    input  logic signed [31:0]  set_x,
    input  logic signed [31:0]  set_y,
    input  logic                queue_full,
    output logic                push,
    output hpe_pkg::op_t        op
);

    logic active_reg, active_next;
    logic skip_reg, skip_next;
    logic base_reg, base_next;
    logic accept;
    logic is_digit, is_term;
    logic [7:0] digit_base;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    // Classify the byte as a digit of the current base
    always_comb
    begin
        is_digit   = 1'b0;
        is_term    = 1'b0;
        digit_base = hpe_pkg::B64_LO;
        if (!base_reg)
        begin
            if (byte_value >= hpe_pkg::B64_TERM_LO && byte_value <= hpe_pkg::B64_TERM_HI)
            begin
                is_digit   = 1'b1;
                is_term    = 1'b1;
                digit_base = hpe_pkg::B64_TERM_LO;
            end
            else if (byte_value >= hpe_pkg::B64_LO && byte_value <= hpe_pkg::B64_HI)
            begin
                is_digit   = 1'b1;
                digit_base = hpe_pkg::B64_LO;
            end
        end
        else
        begin
            if (byte_value >= hpe_pkg::B32_TERM_LO && byte_value <= hpe_pkg::B32_TERM_HI)
            begin
                is_digit   = 1'b1;
                is_term    = 1'b1;
                digit_base = hpe_pkg::B32_TERM_LO;
            end
            else if (byte_value >= hpe_pkg::B32_LO && byte_value <= hpe_pkg::B32_HI)
            begin
                is_digit   = 1'b1;
                digit_base = hpe_pkg::B32_LO;
            end
        end
    end

    // Turn an accepted word into an operation, drop what does nothing
    always_comb
    begin
        active_next = active_reg;
        skip_next   = skip_reg;
        base_next   = base_reg;
        push        = 1'b0;
        op.kind     = hpe_pkg::OP_MARK;
        op.base_32  = base_reg;
        op.digit    = 6'(byte_value - digit_base);
        op.term     = is_term;
        op.set_x    = set_x;
        op.set_y    = set_y;
        if (accept)
        begin
            unique case (command)
                hpe_pkg::CMD_BEGIN:
                begin
                    push        = 1'b1;
                    op.kind     = hpe_pkg::OP_BEGIN;
                    active_next = 1'b1;
                    skip_next   = 1'b0;
                    base_next   = 1'b0;
                end
                hpe_pkg::CMD_SETPOS:
                begin
                    push    = 1'b1;
                    op.kind = hpe_pkg::OP_SETPOS;
                end
                hpe_pkg::CMD_DATA:
                begin
                    if (active_reg)
                    begin
                        priority if (skip_reg)
                        begin
                            skip_next = 1'b0;
                        end
                        else if (byte_value == hpe_pkg::CH_SEMI)
                        begin
                            push        = 1'b1;
                            op.kind     = hpe_pkg::OP_END;
                            active_next = 1'b0;
                        end
                        else if (byte_value == hpe_pkg::CH_COLON)
                        begin
                            push      = 1'b1;
                            op.kind   = hpe_pkg::OP_MARK;
                            skip_next = 1'b1;
                        end
                        else if (byte_value == hpe_pkg::CH_LT)
                        begin
                            push    = 1'b1;
                            op.kind = hpe_pkg::OP_PEN_UP;
                        end
                        else if (byte_value == hpe_pkg::CH_GT)
                        begin
                            push      = 1'b1;
                            op.kind   = hpe_pkg::OP_PEN_DOWN;
                            skip_next = 1'b1;
                        end
                        else if (byte_value == hpe_pkg::CH_EQ)
                        begin
                            push    = 1'b1;
                            op.kind = hpe_pkg::OP_ABS;
                        end
                        else if (byte_value == hpe_pkg::CH_SEVEN)
                        begin
                            push      = 1'b1;
                            op.kind   = hpe_pkg::OP_MARK;
                            base_next = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            push    = 1'b1;
                            op.kind = hpe_pkg::OP_DIGIT;
                        end
                        else
                        begin
                            push = 1'b0;
                        end
                    end
                end
                hpe_pkg::CMD_IDLE:
                begin
                    push = 1'b0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Hold the stream flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            skip_reg   <= 1'b0;
            base_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            skip_reg   <= skip_next;
            base_reg   <= base_next;
        end
    end

endmodule

// ===== rtl/hpe_queue.sv =====
`timescale 1ns / 1ps

module hpe_queue
#(
    parameter int DEPTH = hpe_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hpe_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output hpe_pkg::op_t  head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hpe_pkg::op_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_op  = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/hpe_back.sv =====
`timescale 1ns / 1ps

module hpe_back
#(
    parameter int COORD_BITS = hpe_pkg::COORD_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    input  hpe_pkg::op_t          op,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_take,
    output logic                  res_drawn,
    output logic [COORD_BITS-1:0] res_sx,
    output logic [COORD_BITS-1:0] res_sy,
    output logic [COORD_BITS-1:0] res_ex,
    output logic [COORD_BITS-1:0] res_ey
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] pos_x_reg, pos_x_next;
    logic [CB-1:0] pos_y_reg, pos_y_next;
    logic [CB-1:0] acc_x_reg, acc_x_next;
    logic [CB-1:0] acc_y_reg, acc_y_next;
    logic          pen_reg, pen_next;
    logic          rel_reg, rel_next;
    logic          in_y_reg, in_y_next;
    logic [2:0]    dc_reg, dc_next;
    logic          rs_valid_reg, rs_valid_next;
    logic          rs_drawn_reg;
    logic [CB-1:0] rs_sx_reg, rs_sy_reg, rs_ex_reg, rs_ey_reg;

    logic          pending, finish, go, rs_free;
    logic [5:0]    shift;
    logic [CB-1:0] add, acc_x_sum, acc_y_sum;
    logic [CB-1:0] fin_acc_y, mag_x, mag_y, vx, vy, nx, ny;
    logic [CB-1:0] set_x_ext, set_y_ext;

    assign pending = in_y_reg || (dc_reg != 3'd0);

    // Weight of this digit and the running sums
    assign shift     = op.base_32 ? 6'(dc_reg) * hpe_pkg::B32_DIGIT_BITS
                                  : 6'(dc_reg) * hpe_pkg::B64_DIGIT_BITS;
    assign add       = CB'(op.digit) << shift;
    assign acc_x_sum = acc_x_reg + add;
    assign acc_y_sum = acc_y_reg + add;

    // End point of a finished point
    assign fin_acc_y = (op.kind == hpe_pkg::OP_DIGIT) ? acc_y_sum : acc_y_reg;
    assign mag_x     = acc_x_reg >> 1;
    assign mag_y     = fin_acc_y >> 1;
    assign vx        = acc_x_reg[0] ? CB'(0) - mag_x : mag_x;
    assign vy        = fin_acc_y[0] ? CB'(0) - mag_y : mag_y;
    assign nx        = rel_reg ? pos_x_reg + vx : vx;
    assign ny        = rel_reg ? pos_y_reg + vy : vy;

    assign set_x_ext = CB'(signed'(op.set_x));
    assign set_y_ext = CB'(signed'(op.set_y));

    // Decide whether this operation finishes a point
    always_comb
    begin
        unique case (op.kind)
            hpe_pkg::OP_DIGIT:    finish = op.term && in_y_reg;
            hpe_pkg::OP_END,
            hpe_pkg::OP_MARK,
            hpe_pkg::OP_PEN_UP,
            hpe_pkg::OP_PEN_DOWN,
            hpe_pkg::OP_ABS:      finish = pending;
            default:              finish = 1'b0;
        endcase
    end

    assign rs_free = !rs_valid_reg || res_take;
    assign go      = op_valid && (!finish || rs_free);
    assign pop     = go;

    // Carry out the operation
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        pen_next   = pen_reg;
        rel_next   = rel_reg;
        in_y_next  = in_y_reg;
        dc_next    = dc_reg;
        if (go)
        begin
            unique case (op.kind)
                hpe_pkg::OP_BEGIN:
                begin
                    pen_next   = 1'b1;
                    rel_next   = 1'b1;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    in_y_next  = 1'b0;
                    dc_next    = 3'd0;
                end
                hpe_pkg::OP_SETPOS:
                begin
                    pos_x_next = set_x_ext;
                    pos_y_next = set_y_ext;
                end
                hpe_pkg::OP_DIGIT:
                begin
                    if (in_y_reg)
                    begin
                        acc_y_next = acc_y_sum;
                    end
                    else
                    begin
                        acc_x_next = acc_x_sum;
                    end
                    dc_next = (dc_reg == hpe_pkg::DIGIT_COUNT_MAX) ? dc_reg : dc_reg + 1'b1;
                    if (op.term && !in_y_reg)
                    begin
                        in_y_next = 1'b1;
                        dc_next   = 3'd0;
                    end
                end
                default:
                begin
                    pen_next = pen_reg;
                end
            endcase

            // Close the point
            if (finish)
            begin
                pos_x_next = nx;
                pos_y_next = ny;
                acc_x_next = '0;
                acc_y_next = '0;
                in_y_next  = 1'b0;
                dc_next    = 3'd0;
                rel_next   = 1'b1;
                pen_next   = 1'b1;
            end

            // Apply the flag after the point is closed
            unique case (op.kind)
                hpe_pkg::OP_PEN_UP:   pen_next = 1'b0;
                hpe_pkg::OP_PEN_DOWN: pen_next = 1'b1;
                hpe_pkg::OP_ABS:      rel_next = 1'b0;
                default:              rel_next = rel_next;
            endcase
        end
    end

    // Result stage valid
    always_comb
    begin
        rs_valid_next = rs_valid_reg;
        if (res_take)
        begin
            rs_valid_next = 1'b0;
        end
        if (go && finish)
        begin
            rs_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            pen_reg      <= 1'b0;
            rel_reg      <= 1'b1;
            in_y_reg     <= 1'b0;
            dc_reg       <= 3'd0;
            rs_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            acc_x_reg    <= acc_x_next;
            acc_y_reg    <= acc_y_next;
            pen_reg      <= pen_next;
            rel_reg      <= rel_next;
            in_y_reg     <= in_y_next;
            dc_reg       <= dc_next;
            rs_valid_reg <= rs_valid_next;
        end
    end

    // Capture the segment, unrotated
    always_ff @(posedge clk)
    begin
        if (go && finish)
        begin
            rs_drawn_reg <= pen_reg;
            rs_sx_reg    <= pos_x_reg;
            rs_sy_reg    <= pos_y_reg;
            rs_ex_reg    <= nx;
            rs_ey_reg    <= ny;
        end
    end

    assign res_valid = rs_valid_reg;
    assign res_drawn = rs_drawn_reg;
    assign res_sx    = rs_sx_reg;
    assign res_sy    = rs_sy_reg;
    assign res_ex    = rs_ex_reg;
    assign res_ey    = rs_ey_reg;

endmodule

// ===== rtl/hpe_out.sv =====
`timescale 1ns / 1ps

module hpe_out
#(
    parameter int COORD_BITS = hpe_pkg::COORD_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rotate,
    input  logic                  res_valid,
    output logic                  res_take,
    input  logic                  res_drawn,
    input  logic [COORD_BITS-1:0] res_sx,
    input  logic [COORD_BITS-1:0] res_sy,
    input  logic [COORD_BITS-1:0] res_ex,
    input  logic [COORD_BITS-1:0] res_ey,
    output logic                  seg_valid,
    input  logic                  seg_stall,
    output logic                  drawn,
    output logic signed [31:0]    start_x,
    output logic signed [31:0]    start_y,
    output logic signed [31:0]    end_x,
    output logic signed [31:0]    end_y
);

    localparam int CB = COORD_BITS;

    logic          seg_valid_reg, seg_valid_next;
    logic          drawn_reg;
    logic [31:0]   start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic          ready;
    logic [CB-1:0] rsx, rsy, rex, rey;

    assign ready    = !seg_valid_reg || !seg_stall;
    assign res_take = res_valid && ready;

    // Quarter turn: (x,y) -> (y,-x)
    assign rsx = rotate ? res_sy : res_sx;
    assign rsy = rotate ? CB'(0) - res_sx : res_sy;
    assign rex = rotate ? res_ey : res_ex;
    assign rey = rotate ? CB'(0) - res_ex : res_ey;

    always_comb
    begin
        seg_valid_next = seg_valid_reg;
        if (ready)
        begin
            seg_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= seg_valid_next;
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            drawn_reg   <= res_drawn;
            start_x_reg <= 32'(rsx);
            start_y_reg <= 32'(rsy);
            end_x_reg   <= 32'(rex);
            end_y_reg   <= 32'(rey);
        end
    end

    assign seg_valid = seg_valid_reg;
    assign drawn     = drawn_reg;
    assign start_x   = signed'(start_x_reg);
    assign start_y   = signed'(start_y_reg);
    assign end_x     = signed'(end_x_reg);
    assign end_y     = signed'(end_y_reg);

endmodule
